/* rtl/lfu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, shared types and a saturating-increment helper for the LFU replacement cache and its cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int WAYS       = 8;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int CAP_BITS   = 4;

  localparam int IDX_W = $clog2(WAYS);
  localparam int REC_W = $clog2(WAYS);
  localparam int NV_W  = $clog2(WAYS + 1);
  localparam int CMP_W = (NV_W > CAP_BITS) ? NV_W : CAP_BITS;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [REC_W-1:0]      rec_t;
  typedef logic [NV_W-1:0]       nv_t;
  typedef logic [CAP_BITS-1:0]   cap_t;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_PROBE  = 1'b1;

  localparam cap_t CAP_RESET = cap_t'(8);

  // Token that walks the cell chain and gathers the lookup result.
  typedef struct packed {
    logic   live;
    nv_t    nvalid;
    logic   found;
    idx_t   found_idx;
    count_t found_count;
    rec_t   found_rec;
    logic   free_found;
    idx_t   free_idx;
    logic   vic_found;
    idx_t   vic_idx;
    count_t vic_count;
    rec_t   vic_rec;
    key_t   vic_key;
  } scan_t;

  // Broadcast write to the cells.
  typedef struct packed {
    logic en;
    idx_t way;
    logic fill;
    key_t key;
    rec_t rec_new;
    logic close_en;
    rec_t close_rank;
  } upd_t;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

/* rtl/lfu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface lfu_in_if import lfu_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  key_t key_in;

  modport source (output valid, command, key_in, input ready);
  modport sink   (input valid, command, key_in, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  logic   evicted;
  key_t   evicted_key;
  count_t use_count;

  modport source (output valid, hit, evicted, evicted_key, use_count, input ready);
  modport sink   (input valid, hit, evicted, evicted_key, use_count, output ready);
endinterface

/* rtl/lfu_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache cell
// Holds one way (key, count, recency) and folds it into the passing token.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  idx_t  idx_i,
  input  key_t  req_key_i,
  input  scan_t scan_i,
  output scan_t scan_o,
  input  upd_t  upd_i
);

  logic   valid_q;
  key_t   key_q;
  count_t count_q;
  rec_t   rec_q;

  scan_t  scan_d;
  scan_t  scan_q;
  logic   match;
  logic   better;

  assign match  = valid_q && (key_q == req_key_i);
  assign better = valid_q && (!scan_i.vic_found || (count_q < scan_i.vic_count) ||
                  ((count_q == scan_i.vic_count) && (rec_q < scan_i.vic_rec)));

  always_comb begin
    scan_d = scan_i;
    if (valid_q) begin
      scan_d.nvalid = scan_i.nvalid + nv_t'(1);
    end
    // first matching way wins
    if (match && !scan_i.found) begin
      scan_d.found       = 1'b1;
      scan_d.found_idx   = idx_i;
      scan_d.found_count = count_q;
      scan_d.found_rec   = rec_q;
    end
    if (!valid_q && !scan_i.free_found) begin
      scan_d.free_found = 1'b1;
      scan_d.free_idx   = idx_i;
    end
    if (better) begin
      scan_d.vic_found = 1'b1;
      scan_d.vic_idx   = idx_i;
      scan_d.vic_count = count_q;
      scan_d.vic_rec   = rec_q;
      scan_d.vic_key   = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_i.en && (upd_i.way == idx_i)) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      if (upd_i.way == idx_i) begin
        rec_q <= upd_i.rec_new;
        if (upd_i.fill) begin
          key_q   <= upd_i.key;
          count_q <= count_t'(1);
        end else begin
          count_q <= sat_inc(count_q);
        end
      end else if (upd_i.close_en && valid_q && (rec_q > upd_i.close_rank)) begin
        // close the gap left by the moved entry
        rec_q <= rec_q - rec_t'(1);
      end
    end
  end

endmodule

/* rtl/lfu_cache_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache replacement
// Fully associative key cache, least-frequently-used eviction, LRU tie break.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An accepted item launches a token down a
// chain of WAYS cells, one cell per cycle, which gathers the hit, the first
// free way and the victim; the block then writes the cells and loads the
// result register. The next item is taken once the result register is
// loaded or free. Capacity is taken as 1 when written 0 and as WAYS when
// above it.
module lfu_cache_replacement import lfu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfu_in_if.sink       req_i,
  lfu_out_if.source    rsp_o,
  input  logic         cfg_we_i,
  input  cap_t         cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       start_q;
  cap_t       cap_q;
  logic       cmd_q;
  key_t       key_q;
  scan_t      res_q;

  logic       out_valid_q;
  logic       hit_q, evicted_q;
  key_t       evkey_q;
  count_t     count_q;

  logic       accept;
  logic       commit;
  scan_t      chain [WAYS+1];
  scan_t      head;
  upd_t       upd, upd_bus;
  logic       hit_d, evicted_d;
  key_t       evkey_d;
  count_t     count_d;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] nvalid_w;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    head      = '0;
    head.live = start_q;
  end
  assign chain[0] = head;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    lfu_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (idx_t'(g)),
      .req_key_i (key_q),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1]),
      .upd_i     (upd_bus)
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (chain[WAYS].live) state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      cap_q   <= CAP_RESET;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
      key_q <= req_i.key_in;
    end
    // hold the gathered token while the result register is busy
    if (state_q == ST_SCAN && chain[WAYS].live) begin
      res_q <= chain[WAYS];
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(WAYS)) begin
      eff_cap = CMP_W'(WAYS);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end
  assign nvalid_w = CMP_W'(res_q.nvalid);

  always_comb begin
    upd       = '0;
    upd.key   = key_q;
    hit_d     = res_q.found;
    evicted_d = 1'b0;
    evkey_d   = '0;
    count_d   = '0;
    priority if (res_q.found) begin
      if (cmd_q == CMD_ACCESS) begin
        count_d        = sat_inc(res_q.found_count);
        upd.en         = 1'b1;
        upd.way        = res_q.found_idx;
        upd.rec_new    = rec_t'(res_q.nvalid - nv_t'(1));
        upd.close_en   = 1'b1;
        upd.close_rank = res_q.found_rec;
      end else begin
        count_d = res_q.found_count;
      end
    end else if (cmd_q == CMD_ACCESS) begin
      if ((nvalid_w < eff_cap) && res_q.free_found) begin
        count_d     = count_t'(1);
        upd.en      = 1'b1;
        upd.way     = res_q.free_idx;
        upd.fill    = 1'b1;
        upd.rec_new = rec_t'(res_q.nvalid);
      end else if (res_q.vic_found) begin
        count_d        = count_t'(1);
        evicted_d      = 1'b1;
        evkey_d        = res_q.vic_key;
        upd.en         = 1'b1;
        upd.way        = res_q.vic_idx;
        upd.fill       = 1'b1;
        upd.rec_new    = rec_t'(res_q.nvalid - nv_t'(1));
        upd.close_en   = 1'b1;
        upd.close_rank = res_q.vic_rec;
      end
    end else begin
      // probe miss: all zero
      count_d = '0;
    end
  end

  always_comb begin
    upd_bus    = upd;
    upd_bus.en = upd.en && commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q     <= hit_d;
      evicted_q <= evicted_d;
      evkey_q   <= evkey_d;
      count_q   <= count_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.evicted     = evicted_q;
  assign rsp_o.evicted_key = evkey_q;
  assign rsp_o.use_count   = count_q;

endmodule

/* rtl/lfu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache checker
// Port-level assertions for the LFU replacement cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker import lfu_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input logic   hit_i,
  input logic   evicted_i,
  input key_t   evicted_key_i,
  input count_t use_count_i
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in flight");

  a_evict_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evicted_i |-> !hit_i && (use_count_i == count_t'(1)))
    else $error("eviction result inconsistent");

  a_no_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !evicted_i |-> (evicted_key_i == '0))
    else $error("evicted key set without eviction");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> (use_count_i != '0))
    else $error("hit reported with zero count");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .hit_i         (rsp_o.hit),
  .evicted_i     (rsp_o.evicted),
  .evicted_key_i (rsp_o.evicted_key),
  .use_count_i   (rsp_o.use_count)
);
